>>> src/gmb_pkg.sv
// Package for the grid maze breadth-first search block.
// Holds shared constants; no dependencies.
package gmb_pkg;
   localparam int unsigned MAX_SIDE = 64;
   localparam int unsigned COORD_W = 6;
   localparam int unsigned COORD_REACH = 64;
   localparam int unsigned PATH_W = 13;
   localparam int unsigned SIDE_W = 7;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;
   localparam logic [0:0] REG_GRID_SIDE = 1'b0;
endpackage

>>> src/gmb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmb_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> src/grid_maze_bfs_shortest_path_top.sv
// Top level of the grid maze breadth-first search block.
// Depends on gmb_pkg and gmb_ram (grid, visited map, frontier queue).
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | func, cell, start, end fields
//  rsp     | out       | rsp_valid/rsp_stall | path_cells, reachable
//  csr     | in        | APB psel/penable    | grid_side at address 0
//
// Loads can follow back to back while no search runs. A search first checks its
// end cell, then clears the visited map one entry a cycle, checking the start
// cell with the first entry, then for each dequeued cell steps through its four
// neighbors, reading the grid and visited map only for those inside the grid.
// Ends outside the grid go straight to the done state. The result becomes valid
// in the cycle after the search reaches its done state.
// Reset is synchronous; the grid contents are undefined until loaded.
// A finished result waits in the output register while loads keep flowing.
module grid_maze_bfs_shortest_path_top
   import gmb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [COORD_W-1:0]   req_cell_row,
   input  logic [COORD_W-1:0]   req_cell_col,
   input  logic                 req_cell_open,
   input  logic [COORD_W-1:0]   req_start_row,
   input  logic [COORD_W-1:0]   req_start_col,
   input  logic [COORD_W-1:0]   req_end_row,
   input  logic [COORD_W-1:0]   req_end_col,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PATH_W-1:0]    rsp_path_cells,
   output logic                 rsp_reachable,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [1:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int unsigned AW = $clog2(MAX_SIDE);
   localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
   localparam int unsigned IW = 2 * AW;
   localparam int unsigned DW = IW + 1;
   localparam int unsigned EW = 2 * AW + DW;
   localparam int unsigned LIM = (MAX_SIDE < COORD_REACH) ? MAX_SIDE : COORD_REACH;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK_START, S_CHK_END, S_CLEAR, S_POP, S_POP_WAIT,
      S_NB, S_NB_GRID, S_NB_VIS, S_DONE
   } state_type;

   state_type state_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [AW-1:0] sr_ff, sc_ff, er_ff, ec_ff, cr_ff, cc_ff, nr_ff, nc_ff;
   logic [DW-1:0] cd_ff;
   logic [IW-1:0] clr_ff, head_ff;
   logic [IW:0]   tail_ff;
   logic [1:0]    k_ff;
   logic          rsp_valid_ff, reach_ff;
   logic [PATH_W-1:0] path_ff;

   logic [SIDE_W-1:0] side_use;
   assign side_use = (side_ff > SIDE_W'(LIM)) ? SIDE_W'(LIM) : side_ff;

   // Memories.
   logic g_we, g_rd, v_we, v_wd, v_rd, f_we;
   logic [IW-1:0] g_wa, g_ra, v_wa, v_ra, f_wa, f_ra;
   logic [EW-1:0] f_wd, f_rd;

   gmb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(req_cell_open),
      .rd_addr(g_ra), .rd_data(g_rd));
   gmb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));
   gmb_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_fifo (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));

   logic req_fire, load_fire, search_fire, in_storage;
   assign req_fire = req_valid && !req_stall;
   assign in_storage = (32'(req_cell_row) < MAX_SIDE) && (32'(req_cell_col) < MAX_SIDE);
   assign load_fire = req_fire && (req_func == FUNC_LOAD);
   assign search_fire = req_fire && (req_func == FUNC_SEARCH);
   // Loads pass whenever no search runs; a search needs the output register free.
   assign req_stall = (state_ff != S_IDLE) ||
                      ((req_func == FUNC_SEARCH) && rsp_valid_ff);

   // Neighbor coordinates for direction k: up, left, right, down.
   logic nb_ok;
   logic [AW-1:0] nr, nc;
   always_comb begin
      nb_ok = 1'b0;
      nr = cr_ff;
      nc = cc_ff;
      case (k_ff)
         2'd0: begin nb_ok = (cr_ff != '0); nr = cr_ff - 1'b1; end
         2'd1: begin nb_ok = (cc_ff != '0); nc = cc_ff - 1'b1; end
         2'd2: begin nb_ok = (SIDE_W'(cc_ff) + 1'b1 < side_use); nc = cc_ff + 1'b1; end
         default: begin nb_ok = (SIDE_W'(cr_ff) + 1'b1 < side_use); nr = cr_ff + 1'b1; end
      endcase
   end

   logic [AW-1:0] fr, fc;
   logic [DW-1:0] fd;
   assign {fr, fc, fd} = f_rd;

   always_comb begin
      g_we = load_fire && in_storage;
      g_wa = {req_cell_row[AW-1:0], req_cell_col[AW-1:0]};
      g_ra = {sr_ff, sc_ff};
      v_we = 1'b0; v_wa = clr_ff; v_wd = 1'b0; v_ra = {nr, nc};
      f_we = 1'b0; f_wa = tail_ff[IW-1:0]; f_wd = {nr_ff, nc_ff, cd_ff + 1'b1};
      f_ra = head_ff;
      case (state_ff)
         S_CHK_START: g_ra = {er_ff, ec_ff};
         S_CLEAR: begin
            v_we = 1'b1;
            v_wd = (clr_ff == {sr_ff, sc_ff});
            f_we = (clr_ff == '0);
            f_wa = '0;
            f_wd = {sr_ff, sc_ff, DW'(0)};
         end
         S_NB: g_ra = {nr, nc};
         S_NB_GRID: g_ra = {nr_ff, nc_ff};
         S_NB_VIS: begin
            if (g_rd && !v_rd && (tail_ff < (IW+1)'(CELLS))) begin
               v_we = 1'b1; v_wa = {nr_ff, nc_ff}; v_wd = 1'b1; f_we = 1'b1;
            end
         end
         default: ;
      endcase
      if (state_ff == S_NB_GRID) v_ra = {nr_ff, nc_ff};
   end

   logic [SIDE_W-1:0] max_c;
   assign max_c = SIDE_W'(req_start_row) > SIDE_W'(req_start_col) ?
                  SIDE_W'(req_start_row) : SIDE_W'(req_start_col);
   logic [SIDE_W-1:0] max_e;
   assign max_e = SIDE_W'(req_end_row) > SIDE_W'(req_end_col) ?
                  SIDE_W'(req_end_row) : SIDE_W'(req_end_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff <= SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && paddr[1:0] == {REG_GRID_SIDE, 1'b0}) begin
            side_ff <= pwdata[SIDE_W-1:0];
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (search_fire) begin
                  sr_ff <= req_start_row[AW-1:0]; sc_ff <= req_start_col[AW-1:0];
                  er_ff <= req_end_row[AW-1:0];   ec_ff <= req_end_col[AW-1:0];
                  if (max_c >= side_use || max_e >= side_use) begin
                     reach_ff <= 1'b0; path_ff <= '0; state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_CHK_START;
                  end
               end
            end
            S_CHK_START: state_ff <= S_CHK_END;
            S_CHK_END: begin
               // g_rd holds the end cell now; the start cell follows next cycle.
               if (!g_rd) begin
                  reach_ff <= 1'b0; path_ff <= '0; state_ff <= S_DONE;
               end else begin
                  clr_ff <= '0; state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               if (clr_ff == '0 && !g_rd) begin
                  reach_ff <= 1'b0; path_ff <= '0; state_ff <= S_DONE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
                  if (clr_ff == IW'(CELLS - 1)) begin
                     head_ff <= '0; tail_ff <= (IW+1)'(1); state_ff <= S_POP;
                  end
               end
            end
            S_POP: begin
               if ((IW+1)'(head_ff) < tail_ff) state_ff <= S_POP_WAIT;
               else begin reach_ff <= 1'b0; path_ff <= '0; state_ff <= S_DONE; end
            end
            S_POP_WAIT: begin
               cr_ff <= fr; cc_ff <= fc; cd_ff <= fd;
               if (fr == er_ff && fc == ec_ff) begin
                  reach_ff <= 1'b1; path_ff <= PATH_W'(fd + 1'b1); state_ff <= S_DONE;
               end else if (head_ff == IW'(CELLS - 1)) begin
                  // Popping the last queue entry without reaching the end cell ends the search.
                  reach_ff <= 1'b0; path_ff <= '0; state_ff <= S_DONE;
               end else begin
                  head_ff <= head_ff + 1'b1; k_ff <= 2'd0; state_ff <= S_NB;
               end
            end
            S_NB: begin
               nr_ff <= nr; nc_ff <= nc;
               if (nb_ok) state_ff <= S_NB_GRID;
               else begin
                  k_ff <= k_ff + 1'b1;
                  if (k_ff == 2'd3) state_ff <= S_POP;
               end
            end
            S_NB_GRID: state_ff <= S_NB_VIS;
            S_NB_VIS: begin
               if (f_we) tail_ff <= tail_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 2'd3) ? S_POP : S_NB;
            end
            S_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_path_cells = path_ff;
   assign rsp_reachable = reach_ff;
   assign prdata = 32'(side_ff) & {32{paddr == 2'd0}};
   assign pready = 1'b1;
endmodule

>>> tb/grid_maze_bfs_shortest_path_checker.sv
// Checker for the grid maze breadth-first search block: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on gmb_pkg.
module grid_maze_bfs_shortest_path_checker
   import gmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_cell_row,
   input  logic [COORD_W-1:0] req_cell_col,
   input  logic               req_cell_open,
   input  logic [COORD_W-1:0] req_start_row,
   input  logic [COORD_W-1:0] req_start_col,
   input  logic [COORD_W-1:0] req_end_row,
   input  logic [COORD_W-1:0] req_end_col,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [PATH_W-1:0]  rsp_path_cells,
   input  logic               rsp_reachable,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 paths_pending,
   output int                 mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE_MAX = 64;
   localparam int CELL_COUNT = SIDE_MAX * SIDE_MAX;

   typedef struct packed {
      logic [PATH_W-1:0] path_cells;
      logic              reachable;
   } path_result_type;

   bit                maze[CELL_COUNT];
   logic [SIDE_W-1:0] side_reg;
   path_result_type   path_queue[$];

   // Breadth-first walk over open cells; returns cells on the path, 0 if none.
   function automatic int shortest_path(int sr, int sc, int er, int ec);
      bit seen[CELL_COUNT];
      int qr[CELL_COUNT];
      int qc[CELL_COUNT];
      int qd[CELL_COUNT];
      int head, tail, side, nr, nc, k;
      int dr[4] = '{-1, 0, 0, 1};
      int dc[4] = '{0, -1, 1, 0};
      side = (side_reg > COORD_REACH) ? COORD_REACH : int'(side_reg);
      if (sr >= side || sc >= side || er >= side || ec >= side) return 0;
      if (!maze[sr*SIDE_MAX+sc] || !maze[er*SIDE_MAX+ec]) return 0;
      seen[sr*SIDE_MAX+sc] = 1;
      qr[0] = sr;
      qc[0] = sc;
      qd[0] = 0;
      head = 0;
      tail = 1;
      while (head < tail) begin
         if (qr[head] == er && qc[head] == ec) return qd[head] + 1;
         for (k = 0; k < 4; k++) begin
            nr = qr[head] + dr[k];
            nc = qc[head] + dc[k];
            if (nr < 0 || nc < 0 || nr >= side || nc >= side) continue;
            if (!maze[nr*SIDE_MAX+nc] || seen[nr*SIDE_MAX+nc]) continue;
            if (tail >= CELL_COUNT) continue;
            seen[nr*SIDE_MAX+nc] = 1;
            qr[tail] = nr;
            qc[tail] = nc;
            qd[tail] = qd[head] + 1;
            tail++;
         end
         head++;
      end
      return 0;
   endfunction

   task automatic report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      path_result_type got, want;
      int n;
      if (reset) begin
         side_reg = SIDE_RESET;
      end else begin
         if (psel && penable && pwrite && pready && paddr == 2'(4*REG_GRID_SIDE))
            side_reg = pwdata[SIDE_W-1:0];
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_LOAD) begin
               maze[int'(req_cell_row)*SIDE_MAX + int'(req_cell_col)] = req_cell_open;
            end else begin
               n = shortest_path(req_start_row, req_start_col, req_end_row, req_end_col);
               want.path_cells = PATH_W'(n);
               want.reachable = (n != 0);
               path_queue.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.path_cells = rsp_path_cells;
            got.reachable = rsp_reachable;
            if (path_queue.size() == 0) begin
               report("result transfer with no search outstanding");
            end else begin
               want = path_queue.pop_front();
               if (got.path_cells !== want.path_cells)
                  report($sformatf("path_cells %0d, expected %0d",
                                   got.path_cells, want.path_cells));
               if (got.reachable !== want.reachable)
                  report($sformatf("reachable %0b, expected %0b",
                                   got.reachable, want.reachable));
            end
         end
         paths_pending = path_queue.size();
      end
   end
endmodule

>>> tb/grid_maze_bfs_shortest_path_top_tb.sv
// Testbench top for the grid maze breadth-first search block: drives loads,
// searches and grid side writes, and gives the verdict.
// Depends on gmb_pkg, the block and grid_maze_bfs_shortest_path_checker.
module grid_maze_bfs_shortest_path_top_tb;
   import gmb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_func = FUNC_LOAD;
   logic [COORD_W-1:0] req_cell_row = '0;
   logic [COORD_W-1:0] req_cell_col = '0;
   logic               req_cell_open = 0;
   logic [COORD_W-1:0] req_start_row = '0;
   logic [COORD_W-1:0] req_start_col = '0;
   logic [COORD_W-1:0] req_end_row = '0;
   logic [COORD_W-1:0] req_end_col = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [PATH_W-1:0]  rsp_path_cells;
   logic               rsp_reachable;
   logic               psel = 0;
   logic               penable = 0;
   logic               pwrite = 0;
   logic [1:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   int                 paths_pending;
   int                 mismatches;
   bit                 quiet = 0;
   bit                 long_hold = 0;
   int                 side_now = 64;

   always #1 clock = ~clock;

   grid_maze_bfs_shortest_path_top dut (.*);

   grid_maze_bfs_shortest_path_checker checker_i (.*);

   task automatic write_side(int value);
      @(negedge clock);
      psel = 1;
      pwrite = 1;
      penable = 0;
      paddr = 2'(4*REG_GRID_SIDE);
      pwdata = 32'(value);
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      side_now = (value > 64) ? 64 : value;
   endtask

   // One transfer on the request channel; unused fields carry random values.
   task automatic send(logic func, int a, int b, int c, int d, bit open_bit);
      req_func = func;
      req_cell_row = func == FUNC_LOAD ? COORD_W'(a) : COORD_W'($urandom);
      req_cell_col = func == FUNC_LOAD ? COORD_W'(b) : COORD_W'($urandom);
      req_cell_open = func == FUNC_LOAD ? open_bit : 1'($urandom);
      req_start_row = func == FUNC_SEARCH ? COORD_W'(a) : COORD_W'($urandom);
      req_start_col = func == FUNC_SEARCH ? COORD_W'(b) : COORD_W'($urandom);
      req_end_row = func == FUNC_SEARCH ? COORD_W'(c) : COORD_W'($urandom);
      req_end_col = func == FUNC_SEARCH ? COORD_W'(d) : COORD_W'($urandom);
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_valid = 0;
      wait (paths_pending == 0);
      repeat (10) @(negedge clock);
   endtask

   // Pick a coordinate, mostly inside the side in use.
   function automatic int coord();
      return ($urandom_range(0, 9) == 0 || side_now == 0) ?
             $urandom_range(0, 63) : $urandom_range(0, side_now - 1);
   endfunction

   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1;
            repeat (15000) @(negedge clock);
            long_hold = 0;
            rsp_stall = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall = 0;
         end
      end
   end

   initial begin
      int sides[6] = '{8, 2, 5, 8, 3, 7};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Side above the coordinate reach saturates to the full grid; the two
      // corners are fenced in by walls so no unloaded cell is ever read.
      write_side(100);
      send(FUNC_LOAD, 0, 0, 0, 0, 1);
      send(FUNC_LOAD, 0, 1, 0, 0, 1);
      send(FUNC_LOAD, 1, 0, 0, 0, 0);
      send(FUNC_LOAD, 1, 1, 0, 0, 0);
      send(FUNC_LOAD, 0, 2, 0, 0, 0);
      send(FUNC_LOAD, 63, 63, 0, 0, 1);
      send(FUNC_LOAD, 62, 63, 0, 0, 0);
      send(FUNC_LOAD, 63, 62, 0, 0, 0);
      send(FUNC_SEARCH, 0, 0, 0, 1, 0);
      send(FUNC_SEARCH, 0, 0, 0, 0, 0);
      send(FUNC_SEARCH, 0, 0, 63, 63, 0);
      send(FUNC_SEARCH, 63, 63, 63, 63, 0);
      send(FUNC_SEARCH, 1, 0, 0, 0, 0);
      send(FUNC_SEARCH, 0, 1, 1, 1, 0);
      settle();
      write_side(64);
      send(FUNC_SEARCH, 63, 63, 0, 1, 0);
      settle();
      // An empty grid answers not reachable, and a single cell reaches itself.
      write_side(0);
      send(FUNC_SEARCH, 0, 0, 0, 0, 0);
      settle();
      write_side(1);
      send(FUNC_SEARCH, 0, 0, 0, 0, 0);
      send(FUNC_SEARCH, 0, 1, 0, 0, 0);
      send(FUNC_SEARCH, 0, 0, 0, 1, 0);
      settle();

      // Fill the 8 by 8 corner so every later side of 8 or less is defined.
      write_side(127);
      write_side(8);
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++)
            send(FUNC_LOAD, r, c, 0, 0, $urandom_range(0, 3) != 0);

      for (int p = 0; p < 6; p++) begin
         settle();
         write_side(sides[p]);
         if (p == 2) long_hold = 1;
         if (p == 5) quiet = 1;
         for (int i = 0; i < 130; i++) begin
            if ($urandom_range(0, 4) == 0)
               send(FUNC_SEARCH, coord(), coord(), coord(), coord(), 0);
            else if ($urandom_range(0, 9) == 0)
               send(FUNC_LOAD, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0,
                    $urandom_range(0, 1));
            else
               send(FUNC_LOAD, $urandom_range(0, 7), $urandom_range(0, 7), 0, 0,
                    $urandom_range(0, 9) < 7);
         end
      end

      req_valid = 0;
      wait (paths_pending == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

>>> filelist.f
src/gmb_pkg.sv
src/gmb_ram.sv
src/grid_maze_bfs_shortest_path_top.sv
tb/grid_maze_bfs_shortest_path_checker.sv
tb/grid_maze_bfs_shortest_path_top_tb.sv
